>>> design/svp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_pkg
// Shared types, constants and helpers for the sample voice player.
// ----------------------------------------------------------------------------
package svp_pkg;

  localparam int SVP_SAMPLE_WORDS_DEF  = 65536;
  localparam int SVP_FRACTION_BITS_DEF = 16;

  localparam int SMP_W   = 16;
  localparam int FRAME_W = 17;
  localparam int FETCH_W = FRAME_W + 1;
  localparam int PITCH_W = 21;
  localparam int PAN_W   = 17;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 21;
  localparam int MUL_W   = 31;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int OUT_SH  = 45;

  localparam logic [SMP_W-1:0] Q15_ONE = 16'h8000;
  localparam logic [SMP_W-1:0] Q15_MAX = 16'h7FFF;

  typedef enum logic [CIDX_W-1:0] {
    CFG_NUM_CHANNELS = 3'd0,
    CFG_FRAMES       = 3'd1,
    CFG_LOOP_ENABLE  = 3'd2,
    CFG_TARGET_VOL   = 3'd3,
    CFG_RAMP_STEP    = 3'd4,
    CFG_PITCH_STEP   = 3'd5,
    CFG_SPATIAL_GAIN = 3'd6,
    CFG_PAN          = 3'd7
  } svp_cfg_idx_t;

  typedef struct packed {
    logic               stereo;
    logic [FRAME_W-1:0] frames;
    logic               loop_en;
    logic [SMP_W-1:0]   tgt;
    logic [SMP_W-1:0]   stp;
    logic [PITCH_W-1:0] pitch;
    logic [SMP_W-1:0]   gain;
    logic [SMP_W-1:0]   ldir;
    logic [SMP_W-1:0]   rdir;
  } svp_cfg_t;

  typedef enum logic [14:0] {
    ST_IDLE = 15'h0001,
    ST_GQ   = 15'h0002,
    ST_ML   = 15'h0004,
    ST_LF   = 15'h0008,
    ST_MR   = 15'h0010,
    ST_RF   = 15'h0020,
    ST_RC   = 15'h0040,
    ST_RAMP = 15'h0080,
    ST_Q1   = 15'h0100,
    ST_Q2   = 15'h0200,
    ST_Q3   = 15'h0400,
    ST_FL   = 15'h0800,
    ST_FR   = 15'h1000,
    ST_FW   = 15'h2000,
    ST_OUT  = 15'h4000
  } svp_state_t;

  function automatic logic [SMP_W-1:0] sat_q15(input logic [SMP_W-1:0] v);
    return (v > Q15_ONE) ? Q15_ONE : v;
  endfunction

  function automatic logic [SMP_W-1:0] mag_of(input logic [SMP_W-1:0] raw);
    return raw[SMP_W-1] ? SMP_W'(~raw + 16'd1) : raw;
  endfunction

  // Signed, saturated frame sample from the full unsigned product.
  function automatic logic [SMP_W-1:0] scale_out(input logic [PROD_W-1:0] prod,
                                                 input logic neg);
    logic [16:0] p;
    logic [15:0] c;
    p = prod[OUT_SH +: 17];
    if (neg) begin
      c = (p > 17'({1'b0, Q15_ONE})) ? Q15_ONE : p[15:0];
      return SMP_W'(~c + 16'd1);
    end
    return (p > 17'({1'b0, Q15_MAX})) ? Q15_MAX : p[15:0];
  endfunction

endpackage
`default_nettype wire

>>> design/svp_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module svp_mul
  import svp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [MUL_W-1:0]  a,
  input  wire logic [MUL_W-1:0]  b,
  output logic      [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule
`default_nettype wire

>>> design/svp_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_mem
// Single-port interleaved sample memory, registered read data.
// ----------------------------------------------------------------------------
module svp_mem
  import svp_pkg::*;
#(
  parameter int AW = $clog2(SVP_SAMPLE_WORDS_DEF)
)
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [SMP_W-1:0] wdata,
  output logic      [SMP_W-1:0] rdata_r
);

  localparam int DEPTH = 1 << AW;

  logic [SMP_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

>>> design/svp_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_cfg
// Configuration registers and the saturated gain and pan factors.
// ----------------------------------------------------------------------------
module svp_cfg
  import svp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CDAT_W-1:0] cfg_wdata,
  output svp_cfg_t               cfg
);

  localparam logic signed [PAN_W-1:0] PAN_MAX = 17'sd32768;
  localparam logic signed [PAN_W-1:0] PAN_MIN = -17'sd32768;

  logic [1:0]         nch_r;
  logic [FRAME_W-1:0] frames_r;
  logic               loop_r;
  logic [SMP_W-1:0]   tgt_r;
  logic [SMP_W-1:0]   stp_r;
  logic [PITCH_W-1:0] pitch_r;
  logic [SMP_W-1:0]   gain_r;
  logic [PAN_W-1:0]   pan_r;

  logic signed [PAN_W-1:0] pan_s;
  logic [PAN_W-1:0]        pan_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nch_r    <= 2'd2;
      frames_r <= 17'd1;
      loop_r   <= 1'b0;
      tgt_r    <= 16'd0;
      stp_r    <= Q15_ONE;
      pitch_r  <= 21'd65536;
      gain_r   <= Q15_ONE;
      pan_r    <= 17'd0;
    end else if (cfg_wr_en) begin
      case (svp_cfg_idx_t'(cfg_index))
        CFG_NUM_CHANNELS: nch_r    <= cfg_wdata[1:0];
        CFG_FRAMES:       frames_r <= cfg_wdata[FRAME_W-1:0];
        CFG_LOOP_ENABLE:  loop_r   <= cfg_wdata[0];
        CFG_TARGET_VOL:   tgt_r    <= cfg_wdata[SMP_W-1:0];
        CFG_RAMP_STEP:    stp_r    <= cfg_wdata[SMP_W-1:0];
        CFG_PITCH_STEP:   pitch_r  <= cfg_wdata;
        CFG_SPATIAL_GAIN: gain_r   <= cfg_wdata[SMP_W-1:0];
        CFG_PAN:          pan_r    <= cfg_wdata[PAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pan_s = $signed(pan_r);
    if (pan_s > PAN_MAX) begin
      pan_s = PAN_MAX;
    end else if (pan_s < PAN_MIN) begin
      pan_s = PAN_MIN;
    end
    pan_u = $unsigned(pan_s);

    cfg.stereo  = nch_r[1];
    cfg.frames  = frames_r;
    cfg.loop_en = loop_r;
    cfg.tgt     = sat_q15(tgt_r);
    cfg.stp     = sat_q15(stp_r);
    cfg.pitch   = pitch_r;
    cfg.gain    = sat_q15(gain_r);
    cfg.ldir    = (pan_s > 17'sd0) ? SMP_W'(17'({1'b0, Q15_ONE}) - pan_u) : Q15_ONE;
    cfg.rdir    = (pan_s < 17'sd0) ? SMP_W'(17'({1'b0, Q15_ONE}) + pan_u) : Q15_ONE;
  end

endmodule
`default_nettype wire

>>> design/sample_voice_player_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_voice_player_core
// One sample playback voice: quartic volume ramp, spatial gain and pan,
// looping or one-shot fractional read position.
// ----------------------------------------------------------------------------
//  channel   dir   handshake             payload
//  in_       in    in_valid / in_ready   action, write_address, write_sample,
//                                        hold, close, end_on_silence
//  out_      out   out_valid / out_ready left_out, right_out, finished
//  cfg_      in    cfg_wr_en             cfg_index, cfg_wdata
//
//  A write beat gives no result beat. Hold, close and finished ticks go
//  straight to the output state; an end-of-sample tick skips the ramp and fetches.
//  A playing tick recomputes the quartic volume when the ramp moves: one shared
//  31x31 multiplier runs every product and one memory port does both fetches.
//  in_ready is low while a tick is in work and while its result cannot be
//  placed in the output register. Reset is synchronous; memory is not cleared.
//  SAMPLE_WORDS must be a power of two.
// ----------------------------------------------------------------------------
module sample_voice_player_core
  import svp_pkg::*;
#(
  parameter int SAMPLE_WORDS  = SVP_SAMPLE_WORDS_DEF,
  parameter int FRACTION_BITS = SVP_FRACTION_BITS_DEF
)
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_action,
  input  wire logic [15:0]       in_write_address,
  input  wire logic [15:0]       in_write_sample,
  input  wire logic              in_hold,
  input  wire logic              in_close,
  input  wire logic              in_end_on_silence,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [15:0]            out_left_out,
  output logic [15:0]            out_right_out,
  output logic                   out_finished,
  input  wire logic              cfg_wr_en,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CDAT_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(SAMPLE_WORDS);
  localparam int POS_W = FRACTION_BITS + FRAME_W;
  localparam int AXW   = (AW > FETCH_W) ? AW : FETCH_W;
  localparam int WXW   = (AW > SMP_W) ? AW : SMP_W;

  svp_cfg_t cfg;

  svp_state_t         state_r, state_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [SMP_W-1:0]   vol_r, vol_nxt;
  logic [SMP_W-1:0]   quart_r, quart_nxt;
  logic [SMP_W-1:0]   lhold_r, lhold_nxt;
  logic [SMP_W-1:0]   rhold_r, rhold_nxt;
  logic               done_r, done_nxt;
  logic               close_r, close_nxt;
  logic               eos_r, eos_nxt;
  logic [MUL_W-1:0]   gq_r, gq_nxt;
  logic [SMP_W-1:0]   lo_r, lo_nxt;
  logic [SMP_W-1:0]   ro_r, ro_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SMP_W-1:0]   out_l_r, out_l_nxt;
  logic [SMP_W-1:0]   out_r_r, out_r_nxt;
  logic               out_f_r, out_f_nxt;

  logic               accept;
  logic               mul_en;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  prod_r;
  logic               mem_en, mem_we;
  logic [AW-1:0]      mem_addr;
  logic [SMP_W-1:0]   mem_rdata_r;

  logic [FRAME_W-1:0] pos_int;
  logic [FETCH_W-1:0] base_l, base_r;
  logic [AXW-1:0]     ext_l, ext_r;
  logic [WXW-1:0]     ext_w;
  logic [16:0]        vol_up, tgt_up;
  logic [SMP_W-1:0]   vol_ramp;
  logic               done_fin;

  svp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  svp_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  svp_mem #(.AW(AW)) u_mem (
    .clk     (clk),
    .en      (mem_en),
    .we      (mem_we),
    .addr    (mem_addr),
    .wdata   (in_write_sample),
    .rdata_r (mem_rdata_r)
  );

  assign in_ready      = (state_r == ST_IDLE);
  assign accept        = in_valid & in_ready;
  assign out_valid     = out_valid_r;
  assign out_left_out  = out_l_r;
  assign out_right_out = out_r_r;
  assign out_finished  = out_f_r;

  always_comb begin
    pos_int = pos_r[POS_W-1 -: FRAME_W];
    base_l  = cfg.stereo ? {pos_int, 1'b0} : {1'b0, pos_int};
    base_r  = cfg.stereo ? {pos_int, 1'b1} : {1'b0, pos_int};
    ext_l   = AXW'(base_l);
    ext_r   = AXW'(base_r);
    ext_w   = WXW'(in_write_address);

    vol_up = {1'b0, vol_r} + {1'b0, cfg.stp};
    tgt_up = {1'b0, cfg.tgt} + {1'b0, cfg.stp};
    if (cfg.tgt > vol_r) begin
      vol_ramp = (vol_up >= {1'b0, cfg.tgt}) ? cfg.tgt : vol_up[SMP_W-1:0];
    end else begin
      vol_ramp = ({1'b0, vol_r} <= tgt_up) ? cfg.tgt : vol_r - cfg.stp;
    end

    done_fin = done_r | close_r | (eos_r & (vol_r == 16'd0));
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    vol_nxt       = vol_r;
    quart_nxt     = quart_r;
    lhold_nxt     = lhold_r;
    rhold_nxt     = rhold_r;
    done_nxt      = done_r;
    close_nxt     = close_r;
    eos_nxt       = eos_r;
    gq_nxt        = gq_r;
    lo_nxt        = lo_r;
    ro_nxt        = ro_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_l_nxt     = out_l_r;
    out_r_nxt     = out_r_r;
    out_f_nxt     = out_f_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = ext_w[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_action) begin
            mem_en = 1'b1;
            mem_we = 1'b1;
          end else begin
            close_nxt = in_close;
            eos_nxt   = in_end_on_silence;
            if (done_r || in_hold || in_close) begin
              lo_nxt    = '0;
              ro_nxt    = '0;
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_GQ;
            end
          end
        end
      end
      ST_GQ: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'(quart_r);
        mul_b     = MUL_W'(cfg.gain);
        state_nxt = ST_ML;
      end
      ST_ML: begin
        gq_nxt    = prod_r[MUL_W-1:0];
        mul_en    = 1'b1;
        mul_a     = MUL_W'(mag_of(lhold_r));
        mul_b     = MUL_W'(cfg.ldir);
        state_nxt = ST_LF;
      end
      ST_LF: begin
        mul_en    = 1'b1;
        mul_a     = gq_r;
        mul_b     = prod_r[MUL_W-1:0];
        state_nxt = ST_MR;
      end
      ST_MR: begin
        lo_nxt    = scale_out(prod_r, lhold_r[SMP_W-1]);
        mul_en    = 1'b1;
        mul_a     = MUL_W'(mag_of(rhold_r));
        mul_b     = MUL_W'(cfg.rdir);
        state_nxt = ST_RF;
      end
      ST_RF: begin
        mul_en    = 1'b1;
        mul_a     = gq_r;
        mul_b     = prod_r[MUL_W-1:0];
        state_nxt = ST_RC;
      end
      ST_RC: begin
        ro_nxt    = cfg.stereo ? scale_out(prod_r, rhold_r[SMP_W-1]) : '0;
        state_nxt = ST_RAMP;
        if (pos_int >= cfg.frames) begin
          pos_nxt = '0;
          if (!cfg.loop_en) begin
            done_nxt  = 1'b1;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_RAMP: begin
        if (vol_r != cfg.tgt) begin
          vol_nxt   = vol_ramp;
          state_nxt = ST_Q1;
        end else begin
          state_nxt = ST_FL;
        end
      end
      ST_Q1: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'(vol_r);
        mul_b     = MUL_W'(vol_r);
        state_nxt = ST_Q2;
      end
      ST_Q2: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'(prod_r[30:15]);
        mul_b     = MUL_W'(prod_r[30:15]);
        state_nxt = ST_Q3;
      end
      ST_Q3: begin
        quart_nxt = prod_r[30:15];
        state_nxt = ST_FL;
      end
      ST_FL: begin
        mem_en    = 1'b1;
        mem_addr  = ext_l[AW-1:0];
        state_nxt = ST_FR;
      end
      ST_FR: begin
        mem_en    = 1'b1;
        mem_addr  = ext_r[AW-1:0];
        lhold_nxt = mem_rdata_r;
        state_nxt = ST_FW;
      end
      ST_FW: begin
        rhold_nxt = mem_rdata_r;
        pos_nxt   = POS_W'(pos_r + POS_W'(cfg.pitch));
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_l_nxt     = lo_r;
          out_r_nxt     = ro_r;
          out_f_nxt     = done_fin;
          done_nxt      = done_fin;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      vol_r       <= '0;
      quart_r     <= '0;
      lhold_r     <= '0;
      rhold_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      vol_r       <= vol_nxt;
      quart_r     <= quart_nxt;
      lhold_r     <= lhold_nxt;
      rhold_r     <= rhold_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    close_r <= close_nxt;
    eos_r   <= eos_nxt;
    gq_r    <= gq_nxt;
    lo_r    <= lo_nxt;
    ro_r    <= ro_nxt;
    out_l_r <= out_l_nxt;
    out_r_r <= out_r_nxt;
    out_f_r <= out_f_nxt;
  end

`ifndef SYNTH
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("finished flag dropped");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_action) |=> (state_r == ST_IDLE))
    else $error("write beat started a tick");

  a_done_tick_short: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action && done_r) |=> (state_r == ST_OUT))
    else $error("finished tick took the playback path");

  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vol_r <= Q15_ONE) && (quart_r <= Q15_ONE))
    else $error("volume above unity");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && (!out_valid_r || out_ready)) |=> (out_valid_r && in_ready))
    else $error("result beat not loaded");
`endif

endmodule
`default_nettype wire

>>> dv/svp_voice_tb_pkg.sv
// ----------------------------------------------------------------------------
// svp_voice_tb_pkg
// Beat and frame types plus the frame scoreboard for the voice player bench.
// The scoreboard keeps its own copy of sample memory, read position, volume
// ramp and register state, predicts each output frame when an input beat is
// accepted, and checks frames in order against the block's output.
// ----------------------------------------------------------------------------
package svp_voice_tb_pkg;
  import svp_pkg::*;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam int unsigned UNITY     = 32768;
  localparam int          MEM_WORDS = 65536;

  typedef struct packed {
    logic        action;
    logic [15:0] addr;
    logic [15:0] smp;
    logic        hold;
    logic        close;
    logic        eos;
  } voice_beat_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        finished;
  } frame_t;

  class frame_scoreboard;
    logic [15:0] smp_mem [MEM_WORDS];
    bit          written [MEM_WORDS];
    bit [32:0]   pos;
    int unsigned vol;
    int unsigned quart;
    logic [15:0] l_hold;
    logic [15:0] r_hold;
    bit          done;
    bit [1:0]    nch;
    bit [16:0]   frame_count;
    bit          loop_on;
    bit [15:0]   tgt;
    bit [15:0]   ramp;
    bit [15:0]   gain;
    bit [20:0]   pitch;
    bit [16:0]   pan;
    frame_t      due [$];
    int          errors;

    function new();
      pos         = '0;
      vol         = 0;
      quart       = 0;
      l_hold      = '0;
      r_hold      = '0;
      done        = 1'b0;
      nch         = 2'd2;
      frame_count = 17'd1;
      loop_on     = 1'b0;
      tgt         = '0;
      ramp        = 16'(UNITY);
      pitch       = 21'd65536;
      gain        = 16'(UNITY);
      pan         = '0;
      errors      = 0;
    endfunction

    function void set_reg(svp_cfg_idx_t idx, int unsigned v);
      case (idx)
        CFG_NUM_CHANNELS: nch         = v[1:0];
        CFG_FRAMES:       frame_count = v[16:0];
        CFG_LOOP_ENABLE:  loop_on     = v[0];
        CFG_TARGET_VOL:   tgt         = v[15:0];
        CFG_RAMP_STEP:    ramp        = v[15:0];
        CFG_PITCH_STEP:   pitch       = v[20:0];
        CFG_SPATIAL_GAIN: gain        = v[15:0];
        CFG_PAN:          pan         = v[16:0];
        default: ;
      endcase
    endfunction

    function int unsigned clip_q15(int unsigned v);
      return (v > UNITY) ? UNITY : v;
    endfunction

    function int unsigned quartic(int unsigned v);
      longint unsigned q;
      q = (64'(v) * 64'(v)) >> 15;
      return 32'((q * q) >> 15);
    endfunction

    // sign-magnitude scaling, truncated toward zero, then saturated
    function logic [15:0] scaled(logic [15:0] raw, int unsigned dir);
      bit [63:0] p;
      p = raw[15] ? 64'(17'h10000 - 17'(raw)) : 64'(raw);
      p = (p * 64'(quart) * 64'(clip_q15(gain)) * 64'(dir)) >> 45;
      if (raw[15]) begin
        if (p > 64'd32768) p = 64'd32768;
        return 16'(64'd65536 - p);
      end
      return (p > 64'd32767) ? 16'h7FFF : p[15:0];
    endfunction

    function int unsigned chans();
      return (nch >= 2'd2) ? 2 : 1;
    endfunction

    // words the next playing tick will fetch
    function void fetch_addrs(output logic [15:0] a_left, output logic [15:0] a_right);
      int unsigned ch;
      int unsigned p;
      int unsigned base;
      ch = chans();
      p = pos[32:16];
      if (p >= frame_count) p = 0;
      base = p * ch;
      a_left  = 16'(base);
      a_right = 16'(base + ch - 1);
    endfunction

    // end-on-silence cannot fire while this holds
    function bit silence_safe();
      return vol != 0 && clip_q15(tgt) != 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void note_beat(voice_beat_t b);
      int unsigned ch;
      int unsigned ldir;
      int unsigned rdir;
      int unsigned t;
      int unsigned s;
      int unsigned base;
      int          pn;
      bit          ended;
      frame_t      f;
      if (b.action == ACT_WRITE) begin
        smp_mem[b.addr] = b.smp;
        written[b.addr] = 1'b1;
        return;
      end
      f = '0;
      if (done) begin
        f.finished = 1'b1;
        due = {due, f};
        return;
      end
      ch = chans();
      pn = $signed(pan);
      if (pn > 32768) pn = 32768;
      if (pn < -32768) pn = -32768;
      ldir = (pn > 0) ? 32'(int'(UNITY) - pn) : UNITY;
      rdir = (pn < 0) ? 32'(int'(UNITY) + pn) : UNITY;
      if (!b.hold && !b.close) begin
        f.left = scaled(l_hold, ldir);
        if (ch == 2) f.right = scaled(r_hold, rdir);
        ended = 1'b0;
        if (pos[32:16] >= frame_count) begin
          pos = '0;
          if (!loop_on) begin
            done  = 1'b1;
            ended = 1'b1;
          end
        end
        if (!ended) begin
          t = clip_q15(tgt);
          s = clip_q15(ramp);
          if (vol != t) begin
            if (t > vol) vol = (vol + s >= t) ? t : vol + s;
            else vol = (vol <= t + s) ? t : vol - s;
            quart = quartic(vol);
          end
          base = pos[32:16] * ch;
          l_hold = smp_mem[16'(base)];
          r_hold = smp_mem[16'(base + ch - 1)];
          pos = pos + 33'(pitch);
        end
      end
      if ((vol == 0 && b.eos) || b.close) done = 1'b1;
      f.finished = done;
      due = {due, f};
    endfunction

    function void check_frame(frame_t got);
      frame_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected frame: L=%h R=%h fin=%b", got.left, got.right, got.finished);
        return;
      end
      want = due.pop_front();
      if (got.left !== want.left || got.right !== want.right ||
          got.finished !== want.finished) begin
        errors++;
        if (errors <= 10)
          $display("frame mismatch: expected L=%h R=%h fin=%b, got L=%h R=%h fin=%b",
                   want.left, want.right, want.finished,
                   got.left, got.right, got.finished);
      end
    endfunction
  endclass

endpackage

>>> dv/sample_voice_player_core_tb.sv
// ----------------------------------------------------------------------------
// sample_voice_player_core_tb
// Drives write and tick beats into the voice player with random gaps and
// output stalls, walks through directed and random register setups while
// the block is idle, and ends playback once by close, silence or end of
// sample. Every frame is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module sample_voice_player_core_tb;
  import svp_pkg::*;
  import svp_voice_tb_pkg::*;

  typedef enum {BY_CLOSE, BY_SILENCE, BY_WRAP} finish_cause_t;

  logic               clk               = 1'b0;
  logic               rst_n             = 1'b0;
  logic               in_valid          = 1'b0;
  logic               in_action         = 1'b0;
  logic [15:0]        in_write_address  = '0;
  logic [15:0]        in_write_sample   = '0;
  logic               in_hold           = 1'b0;
  logic               in_close          = 1'b0;
  logic               in_end_on_silence = 1'b0;
  logic               out_ready         = 1'b0;
  logic               cfg_wr_en         = 1'b0;
  svp_cfg_idx_t       cfg_index         = CFG_NUM_CHANNELS;
  logic [CDAT_W-1:0]  cfg_wdata         = '0;
  logic               in_ready;
  logic               out_valid;
  logic [15:0]        out_left_out;
  logic [15:0]        out_right_out;
  logic               out_finished;

  bit                 calm = 1'b0;
  frame_scoreboard    sb;

  sample_voice_player_core uut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_frame('{out_left_out, out_right_out, out_finished});
    end
  end

  task automatic send(voice_beat_t b);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= b.action;
    in_write_address  <= b.addr;
    in_write_sample   <= b.smp;
    in_hold           <= b.hold;
    in_close          <= b.close;
    in_end_on_silence <= b.eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(b);
  endtask

  task automatic write_word(logic [15:0] a, logic [15:0] d);
    voice_beat_t b;
    b = '{ACT_WRITE, a, d, 1'($urandom), 1'($urandom), 1'($urandom)};
    send(b);
  endtask

  // fills any word the tick would fetch that was never written
  task automatic tick(logic hold, logic close, logic eos);
    logic [15:0] a_l;
    logic [15:0] a_r;
    voice_beat_t b;
    sb.fetch_addrs(a_l, a_r);
    if (!sb.written[a_l]) write_word(a_l, 16'($urandom));
    if (!sb.written[a_r]) write_word(a_r, 16'($urandom));
    b = '{ACT_TICK, 16'($urandom), 16'($urandom), hold, close, eos};
    send(b);
  endtask

  task automatic random_tick();
    logic hold;
    logic eos;
    hold = ($urandom_range(0, 9) == 0);
    eos  = sb.silence_safe() ? 1'($urandom) : 1'b0;
    tick(hold, 1'b0, eos);
  endtask

  task automatic write_reg(svp_cfg_idx_t idx, int unsigned value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CDAT_W'(value);
    @(posedge clk);
    sb.set_reg(idx, value);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned nch, frames, loop_en, tgt, ramp, pitch,
                           gain, pan);
    write_reg(CFG_NUM_CHANNELS, nch);
    write_reg(CFG_FRAMES, frames);
    write_reg(CFG_LOOP_ENABLE, loop_en);
    write_reg(CFG_TARGET_VOL, tgt);
    write_reg(CFG_RAMP_STEP, ramp);
    write_reg(CFG_PITCH_STEP, pitch);
    write_reg(CFG_SPATIAL_GAIN, gain);
    write_reg(CFG_PAN, pan);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // write beats give no frame, so let a last one finish as well
  task automatic settle();
    drain();
    repeat (20) @(posedge clk);
  endtask

  function automatic int unsigned pick_q15(int unsigned typical_max);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return UNITY;
      2:       return $urandom_range(UNITY + 1, 65535);
      default: return $urandom_range(1, typical_max);
    endcase
  endfunction

  task automatic random_setup();
    int unsigned frames;
    int unsigned pitch;
    int unsigned pan;
    case ($urandom_range(0, 7))
      0:       frames = 0;
      1:       frames = 65536;
      2:       frames = $urandom_range(1, 131071);
      default: frames = $urandom_range(1, 48);
    endcase
    case ($urandom_range(0, 6))
      0:       pitch = 0;
      1:       pitch = 1048576;
      2:       pitch = $urandom_range(0, 2097151);
      default: pitch = $urandom_range(1, 196608);
    endcase
    case ($urandom_range(0, 5))
      0:       pan = 17'h10000;
      1:       pan = 17'h0FFFF;
      2:       pan = 0;
      default: pan = $urandom_range(0, 131071);
    endcase
    configure($urandom_range(0, 3), frames, 1, pick_q15(32767), pick_q15(4096), pitch,
              pick_q15(32767), pan);
  endtask

  initial begin
    #(12 * 800000);
    $display("sample_voice_player_core_tb: done, errors");
    $finish;
  end

  initial begin
    finish_cause_t cause;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full-scale words, hold, loop wrap, pan and saturation corners
    configure(2, 4, 1, UNITY, UNITY, 65536, UNITY, 0);
    write_word(16'h0000, 16'h8000);
    write_word(16'h0001, 16'h7FFF);
    write_word(16'h0002, 16'h0001);
    write_word(16'h0003, 16'hFFFF);
    write_word(16'h0004, 16'h4000);
    write_word(16'h0005, 16'hC000);
    write_word(16'h0006, 16'h0000);
    write_word(16'h0007, 16'h8001);
    write_word(16'hFFFF, 16'h5A5A);
    tick(1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b0, 1'b0);
    tick(1'b1, 1'b0, 1'b0);
    tick(1'b0, 1'b0, 1'b1);
    tick(1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b0, 1'b0);
    settle();
    configure(1, 3, 1, 16'hFFFF, 16'hFFFF, 32768, 16'hFFFF, 17'h10000);
    repeat (3) tick(1'b0, 1'b0, 1'b0);
    settle();
    configure(0, 0, 1, 16384, 1, 1048576, 16384, 17'h0FFFF);
    repeat (2) tick(1'b0, 1'b0, 1'b0);
    settle();
    configure(3, 2, 1, UNITY, 0, 0, UNITY, 17'h18000);
    repeat (2) tick(1'b0, 1'b0, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      random_setup();
      calm = (ph == 3);
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 4) == 0) write_word(16'($urandom), 16'($urandom));
        else random_tick();
        if (ph == 5 && n == 55) drain();
      end
    end
    calm = 1'b0;

    // bring the position back near zero, then play one-shot until finished
    settle();
    configure(2, 0, 1, UNITY, UNITY, 65536, UNITY, 0);
    tick(1'b0, 1'b0, 1'b0);
    settle();
    write_reg(CFG_FRAMES, 65536);
    write_reg(CFG_LOOP_ENABLE, 0);
    repeat (4) random_tick();
    cause = finish_cause_t'($urandom_range(0, 2));
    case (cause)
      BY_CLOSE: tick(1'b0, 1'b1, 1'b0);
      BY_SILENCE: begin
        settle();
        write_reg(CFG_TARGET_VOL, 0);
        tick(1'b0, 1'b0, 1'b1);
      end
      BY_WRAP: begin
        settle();
        write_reg(CFG_FRAMES, 1);
        repeat (2) tick(1'b0, 1'b0, 1'b0);
      end
      default: ;
    endcase
    tick(1'b1, 1'b1, 1'b1);
    repeat (10) begin
      if ($urandom_range(0, 3) == 0) write_word(16'($urandom), 16'($urandom));
      else tick(1'($urandom), 1'($urandom), 1'($urandom));
    end

    drain();
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sample_voice_player_core_tb: done, clean");
    end else begin
      $display("sample_voice_player_core_tb: done, errors");
    end
    $finish;
  end

endmodule
